FILE: rtl/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg
// shared types and constants for the tree path minimum block
// ----------------------------------------------------------------------------
package tpm_pkg;

   localparam int NODE_W   = 16;
   localparam int DEPTH_W  = 16;
   localparam int WEIGHT_W = 31;
   localparam int LVL_W    = 5;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_LD_DEP,
      S_LD_RD,
      S_LD_WR,
      S_Q_DA,
      S_Q_DB,
      S_LF_A,
      S_LF_U,
      S_LF_C,
      S_EQ,
      S_DV_A,
      S_DV_B,
      S_DV_C,
      S_DV_TOP,
      S_DV_T2,
      S_TOPD,
      S_CL_INIT,
      S_CL_A,
      S_CL_U,
      S_CL_C,
      S_CL_M,
      S_OUT
   } state_type;

   // table port requests from the sequencer
   typedef struct packed {
      logic [NODE_W-1:0]   dep_rd_node;
      logic                dep_wr_en;
      logic [NODE_W-1:0]   dep_wr_node;
      logic [DEPTH_W-1:0]  dep_wr_data;
      logic [NODE_W-1:0]   jmp_rd_node;
      logic [LVL_W-1:0]    jmp_rd_lvl;
      logic                jmp_wr_en;
      logic [NODE_W-1:0]   jmp_wr_node;
      logic [LVL_W-1:0]    jmp_wr_lvl;
      logic [NODE_W-1:0]   jmp_wr_anc;
      logic [WEIGHT_W-1:0] jmp_wr_min;
   } tbl_req_type;

   // registered read data
   typedef struct packed {
      logic [DEPTH_W-1:0]  dep;
      logic [NODE_W-1:0]   anc;
      logic [WEIGHT_W-1:0] wmin;
   } tbl_rsp_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage

FILE: rtl/tree_path_min_binary_lifting.sv
// ----------------------------------------------------------------------------
// tree_path_min_binary_lifting
// binary lifting tables with lowest common ancestor path minimum queries
// ----------------------------------------------------------------------------
// throughput: one item at a time; every level step is a dependent memory read
//   through the single read port of each table, then one shared compare
// reset: clears the sequencer and output valid only, root entries are forced
//   on read so no table clearing pass is needed
module tree_path_min_binary_lifting #(
   parameter int NODES  = 65536,
   parameter int LEVELS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [tpm_pkg::NODE_W-1:0]    req_node_a,
   input  logic [tpm_pkg::NODE_W-1:0]    req_node_b,
   input  logic [tpm_pkg::WEIGHT_W-1:0]  req_edge_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tpm_pkg::WEIGHT_W-1:0]  rsp_path_min
);
   import tpm_pkg::*;

   // table requests and registered read data
   tbl_req_type         tbl_req;
   tbl_rsp_type         tbl_rsp;

   // shared compare unit operands and flags
   logic [WEIGHT_W-1:0] cmp_a;
   logic [WEIGHT_W-1:0] cmp_b;
   cmp_res_type         cmp_res;

   // sequencer: load walks levels upward, query lifts, descends, then climbs
   // twice accumulating the minimum edge weight
   tpm_seq #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_edge_weight (req_edge_weight),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_path_min    (rsp_path_min),
      .tbl_req         (tbl_req),
      .tbl_rsp         (tbl_rsp),
      .cmp_a           (cmp_a),
      .cmp_b           (cmp_b),
      .cmp_res         (cmp_res)
   );

   // depth memory plus ancestor and min weight tables, node-major by level
   tpm_tables #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_tables (
      .clock   (clock),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   // one comparator serves depth tests, ancestor equality and running min
   tpm_cmp u_cmp (
      .op_a (cmp_a),
      .op_b (cmp_b),
      .res  (cmp_res)
   );

endmodule

FILE: rtl/tpm_tables.sv
// ----------------------------------------------------------------------------
// tpm_tables
// depth memory and jump tables (ancestor and min weight) with root override
// ----------------------------------------------------------------------------
module tpm_tables #(
   parameter int NODES  = 65536,
   parameter int LEVELS = 16
) (
   input  logic                clock,
   input  tpm_pkg::tbl_req_type tbl_req,
   output tpm_pkg::tbl_rsp_type tbl_rsp
);
   import tpm_pkg::*;

   localparam int MEM_N  = (NODES > (1 << NODE_W)) ? (1 << NODE_W) : NODES;
   localparam int NAW    = $clog2(MEM_N);
   localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int JAW    = NAW + LW;
   localparam int JMP_N  = MEM_N * (1 << LW);

   logic [DEPTH_W-1:0]  depth_mem [MEM_N];
   logic [NODE_W-1:0]   anc_mem   [JMP_N];
   logic [WEIGHT_W-1:0] min_mem   [JMP_N];

   logic [NAW-1:0]      dep_rd_addr;
   logic [NAW-1:0]      dep_wr_addr;
   logic [JAW-1:0]      jmp_rd_addr;
   logic [JAW-1:0]      jmp_wr_addr;

   logic [DEPTH_W-1:0]  dep_q_ff;
   logic [NODE_W-1:0]   anc_q_ff;
   logic [WEIGHT_W-1:0] min_q_ff;
   logic                dep_root_ff;
   logic                jmp_root_ff;

   assign dep_rd_addr = tbl_req.dep_rd_node[NAW-1:0];
   assign dep_wr_addr = tbl_req.dep_wr_node[NAW-1:0];
   assign jmp_rd_addr = {tbl_req.jmp_rd_node[NAW-1:0], tbl_req.jmp_rd_lvl[LW-1:0]};
   assign jmp_wr_addr = {tbl_req.jmp_wr_node[NAW-1:0], tbl_req.jmp_wr_lvl[LW-1:0]};

   always_ff @(posedge clock) begin
      if (tbl_req.dep_wr_en) begin
         depth_mem[dep_wr_addr] <= tbl_req.dep_wr_data;
      end
      dep_q_ff    <= depth_mem[dep_rd_addr];
      dep_root_ff <= (tbl_req.dep_rd_node == '0);
   end

   always_ff @(posedge clock) begin
      if (tbl_req.jmp_wr_en) begin
         anc_mem[jmp_wr_addr] <= tbl_req.jmp_wr_anc;
         min_mem[jmp_wr_addr] <= tbl_req.jmp_wr_min;
      end
      anc_q_ff    <= anc_mem[jmp_rd_addr];
      min_q_ff    <= min_mem[jmp_rd_addr];
      jmp_root_ff <= (tbl_req.jmp_rd_node == '0);
   end

   // root is never written, its entries come from here
   assign tbl_rsp.dep  = dep_root_ff ? '0 : dep_q_ff;
   assign tbl_rsp.anc  = jmp_root_ff ? '0 : anc_q_ff;
   assign tbl_rsp.wmin = jmp_root_ff ? WEIGHT_MAX : min_q_ff;

endmodule

FILE: rtl/tpm_cmp.sv
// ----------------------------------------------------------------------------
// tpm_cmp
// shared unsigned compare unit for depth, node and weight tests
// ----------------------------------------------------------------------------
module tpm_cmp (
   input  logic [tpm_pkg::WEIGHT_W-1:0] op_a,
   input  logic [tpm_pkg::WEIGHT_W-1:0] op_b,
   output tpm_pkg::cmp_res_type         res
);
   import tpm_pkg::*;

   assign res.lt = (op_a < op_b);
   assign res.eq = (op_a == op_b);

endmodule

FILE: rtl/tpm_seq.sv
// ----------------------------------------------------------------------------
// tpm_seq
// sequencer for table loads and path minimum queries
// ----------------------------------------------------------------------------
module tpm_seq #(
   parameter int NODES  = 65536,
   parameter int LEVELS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [tpm_pkg::NODE_W-1:0]    req_node_a,
   input  logic [tpm_pkg::NODE_W-1:0]    req_node_b,
   input  logic [tpm_pkg::WEIGHT_W-1:0]  req_edge_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tpm_pkg::WEIGHT_W-1:0]  rsp_path_min,
   output tpm_pkg::tbl_req_type          tbl_req,
   input  tpm_pkg::tbl_rsp_type          tbl_rsp,
   output logic [tpm_pkg::WEIGHT_W-1:0]  cmp_a,
   output logic [tpm_pkg::WEIGHT_W-1:0]  cmp_b,
   input  tpm_pkg::cmp_res_type          cmp_res
);
   import tpm_pkg::*;

   localparam int          LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam logic [LW-1:0] K_TOP = LW'(LEVELS - 1);

   state_type            state_ff, state_in;
   logic                 type_ff, type_in;
   logic [NODE_W-1:0]    a_ff, a_in;
   logic [NODE_W-1:0]    b_ff, b_in;
   logic [WEIGHT_W-1:0]  w_ff, w_in;
   logic [NODE_W-1:0]    x_ff, x_in;
   logic [NODE_W-1:0]    y_ff, y_in;
   logic [NODE_W-1:0]    up_ff, up_in;
   logic [LW-1:0]        k_ff, k_in;
   logic [DEPTH_W-1:0]   tdep_ff, tdep_in;
   logic [WEIGHT_W-1:0]  wt_ff, wt_in;
   logic [WEIGHT_W-1:0]  best_ff, best_in;
   logic                 pass_ff, pass_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0]  rsp_min_ff, rsp_min_in;

   function automatic logic node_ok(input logic [NODE_W-1:0] n);
      return (32'(n) < 32'(NODES));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      w_ff       <= w_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      up_ff      <= up_in;
      k_ff       <= k_in;
      tdep_ff    <= tdep_in;
      wt_ff      <= wt_in;
      best_ff    <= best_in;
      pass_ff    <= pass_in;
      rsp_min_ff <= rsp_min_in;
   end

   always_comb begin
      logic                cl_adv;
      logic [WEIGHT_W-1:0] new_min;

      state_in     = state_ff;
      type_in      = type_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      up_in        = up_ff;
      k_in         = k_ff;
      tdep_in      = tdep_ff;
      wt_in        = wt_ff;
      best_in      = best_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      req_ready    = 1'b0;
      tbl_req      = '0;
      cmp_a        = '0;
      cmp_b        = '0;
      cl_adv       = 1'b0;
      new_min      = best_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in  = req_type;
               a_in     = req_node_a;
               b_in     = req_node_b;
               w_in     = req_edge_weight;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // parent must have a lower node index than the loaded node
            cmp_a = WEIGHT_W'(b_ff);
            cmp_b = WEIGHT_W'(a_ff);
            tbl_req.dep_rd_node = (type_ff == REQ_LOAD) ? b_ff : a_ff;
            if (!(node_ok(a_ff) && node_ok(b_ff))) begin
               state_in = S_IDLE;
            end else if (type_ff == REQ_LOAD) begin
               state_in = (a_ff != '0 && cmp_res.lt) ? S_LD_DEP : S_IDLE;
            end else begin
               state_in = S_Q_DA;
            end
         end
         S_LD_DEP: begin
            tbl_req.dep_wr_en   = 1'b1;
            tbl_req.dep_wr_node = a_ff;
            tbl_req.dep_wr_data = tbl_rsp.dep + DEPTH_W'(1);
            tbl_req.jmp_wr_en   = 1'b1;
            tbl_req.jmp_wr_node = a_ff;
            tbl_req.jmp_wr_lvl  = '0;
            tbl_req.jmp_wr_anc  = b_ff;
            tbl_req.jmp_wr_min  = w_ff;
            up_in   = b_ff;
            best_in = w_ff;
            k_in    = LW'(1);
            state_in = (LEVELS == 1) ? S_IDLE : S_LD_RD;
         end
         S_LD_RD: begin
            tbl_req.jmp_rd_node = up_ff;
            tbl_req.jmp_rd_lvl  = LVL_W'(k_ff - LW'(1));
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            cmp_a   = tbl_rsp.wmin;
            cmp_b   = best_ff;
            new_min = cmp_res.lt ? tbl_rsp.wmin : best_ff;
            tbl_req.jmp_wr_en   = 1'b1;
            tbl_req.jmp_wr_node = a_ff;
            tbl_req.jmp_wr_lvl  = LVL_W'(k_ff);
            tbl_req.jmp_wr_anc  = tbl_rsp.anc;
            tbl_req.jmp_wr_min  = new_min;
            up_in   = tbl_rsp.anc;
            best_in = new_min;
            if (k_ff == K_TOP) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + LW'(1);
               state_in = S_LD_RD;
            end
         end
         S_Q_DA: begin
            tdep_in = tbl_rsp.dep;
            tbl_req.dep_rd_node = b_ff;
            state_in = S_Q_DB;
         end
         S_Q_DB: begin
            // deeper node climbs, target depth is the shallower one
            cmp_a = WEIGHT_W'(tdep_ff);
            cmp_b = WEIGHT_W'(tbl_rsp.dep);
            if (cmp_res.lt) begin
               x_in = b_ff;
               y_in = a_ff;
            end else begin
               x_in    = a_ff;
               y_in    = b_ff;
               tdep_in = tbl_rsp.dep;
            end
            k_in     = K_TOP;
            state_in = S_LF_A;
         end
         S_LF_A: begin
            tbl_req.jmp_rd_node = x_ff;
            tbl_req.jmp_rd_lvl  = LVL_W'(k_ff);
            state_in = S_LF_U;
         end
         S_LF_U: begin
            up_in = tbl_rsp.anc;
            tbl_req.dep_rd_node = tbl_rsp.anc;
            state_in = S_LF_C;
         end
         S_LF_C: begin
            cmp_a = WEIGHT_W'(tbl_rsp.dep);
            cmp_b = WEIGHT_W'(tdep_ff);
            if (!cmp_res.lt) begin
               x_in = up_ff;
            end
            if (k_ff == '0) begin
               state_in = S_EQ;
            end else begin
               k_in     = k_ff - LW'(1);
               state_in = S_LF_A;
            end
         end
         S_EQ: begin
            cmp_a = WEIGHT_W'(x_ff);
            cmp_b = WEIGHT_W'(y_ff);
            if (cmp_res.eq) begin
               state_in = S_TOPD;
            end else begin
               k_in     = K_TOP;
               state_in = S_DV_A;
            end
         end
         S_DV_A: begin
            tbl_req.jmp_rd_node = x_ff;
            tbl_req.jmp_rd_lvl  = LVL_W'(k_ff);
            state_in = S_DV_B;
         end
         S_DV_B: begin
            up_in = tbl_rsp.anc;
            tbl_req.jmp_rd_node = y_ff;
            tbl_req.jmp_rd_lvl  = LVL_W'(k_ff);
            state_in = S_DV_C;
         end
         S_DV_C: begin
            cmp_a = WEIGHT_W'(up_ff);
            cmp_b = WEIGHT_W'(tbl_rsp.anc);
            if (!cmp_res.eq) begin
               x_in = up_ff;
               y_in = tbl_rsp.anc;
            end
            if (k_ff == '0) begin
               state_in = S_DV_TOP;
            end else begin
               k_in     = k_ff - LW'(1);
               state_in = S_DV_A;
            end
         end
         S_DV_TOP: begin
            tbl_req.jmp_rd_node = y_ff;
            tbl_req.jmp_rd_lvl  = '0;
            state_in = S_DV_T2;
         end
         S_DV_T2: begin
            y_in     = tbl_rsp.anc;
            state_in = S_TOPD;
         end
         S_TOPD: begin
            // y holds the common ancestor here
            tbl_req.dep_rd_node = y_ff;
            state_in = S_CL_INIT;
         end
         S_CL_INIT: begin
            tdep_in  = tbl_rsp.dep;
            x_in     = a_ff;
            best_in  = WEIGHT_MAX;
            pass_in  = 1'b0;
            k_in     = K_TOP;
            state_in = S_CL_A;
         end
         S_CL_A: begin
            tbl_req.jmp_rd_node = x_ff;
            tbl_req.jmp_rd_lvl  = LVL_W'(k_ff);
            state_in = S_CL_U;
         end
         S_CL_U: begin
            up_in = tbl_rsp.anc;
            wt_in = tbl_rsp.wmin;
            tbl_req.dep_rd_node = tbl_rsp.anc;
            state_in = S_CL_C;
         end
         S_CL_C: begin
            cmp_a = WEIGHT_W'(tbl_rsp.dep);
            cmp_b = WEIGHT_W'(tdep_ff);
            if (!cmp_res.lt) begin
               x_in     = up_ff;
               state_in = S_CL_M;
            end else begin
               cl_adv = 1'b1;
            end
         end
         S_CL_M: begin
            cmp_a = wt_ff;
            cmp_b = best_ff;
            if (cmp_res.lt) begin
               best_in = wt_ff;
            end
            cl_adv = 1'b1;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = best_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // next climb level, second pass starts from the other node
      if (cl_adv) begin
         if (k_ff == '0) begin
            if (!pass_ff) begin
               x_in     = b_ff;
               pass_in  = 1'b1;
               k_in     = K_TOP;
               state_in = S_CL_A;
            end else begin
               state_in = S_OUT;
            end
         end else begin
            k_in     = k_ff - LW'(1);
            state_in = S_CL_A;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_path_min = rsp_min_ff;

endmodule

FILE: rtl/tpm_checker.sv
// ----------------------------------------------------------------------------
// tpm_checker
// port level checks for the tree path minimum block
// ----------------------------------------------------------------------------
module tpm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tpm_pkg::WEIGHT_W-1:0]  rsp_path_min
);
   import tpm_pkg::*;

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

   // a word never appears in the cycle right after an accept
   a_no_early_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("word appeared one cycle after accept");

   // stalled word holds
   a_word_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_path_min))
      else $error("stalled word changed");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind tree_path_min_binary_lifting tpm_checker u_tpm_checker (.*);
